// ===== design/wav_pkg.sv =====
package wav_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       end_of_stream;
    } wav_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  sample;
        logic [31:0] sample_rate;
        logic [15:0] channels;
        logic [15:0] bits_per_sample;
        logic [31:0] total_frames;
    } wav_out_t;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [2:0] K_SAMPLE    = 3'd0;
    localparam logic [2:0] K_HEADER    = 3'd1;
    localparam logic [2:0] K_UNSUP     = 3'd2;
    localparam logic [2:0] K_MALFORMED = 3'd3;
    localparam logic [2:0] K_FINISHED  = 3'd4;
    localparam logic [2:0] K_TRUNC     = 3'd5;
    localparam logic [2:0] K_IDLE      = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [7:0]  MID_LEVEL = 8'd128;

    // Work handed from the parser to the sample stage.
    typedef enum logic [1:0] {
        OP_STATUS,
        OP_MIX8,
        OP_MIX16
    } wav_op_t;

    typedef struct packed {
        wav_op_t     op;
        logic        stereo;
        logic [31:0] frame;
        wav_out_t    res;
    } wav_job_t;

endpackage

// ===== design/wav_parse.sv =====
module wav_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  wav_pkg::wav_in_t  in_word,
    output logic              in_ready,
    output logic              job_valid,
    output wav_pkg::wav_job_t job,
    input  logic              job_ready
);
    import wav_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CLEN,
        PH_FMT, PH_SKIP, PH_DATA, PH_FINISH, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bif_reg, bif_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [32:0] skip_reg, skip_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [31:0] left_reg, left_next;
    logic [2:0]  fsize_reg, fsize_next;
    logic [1:0]  fsh_reg, fsh_next;
    logic [7:0]  fb_reg [4];

    logic        take;
    logic        emit;
    wav_job_t    j;
    logic [31:0] v;
    logic [16:0] fsz;
    logic [2:0]  fsz3;
    logic        bad;
    logic        data_wr;

    assign in_ready = job_ready;
    assign take     = in_valid && in_ready;
    assign v        = shift_reg | ({24'd0, in_word.data_byte} << {bif_reg[1:0], 3'b000});

    always_comb
    begin
        fsz  = 17'({1'b0, bits_reg[15:3]}) * 17'(chan_reg);
        fsz3 = (fsz >= 17'd1 && fsz <= 17'd4) ? fsz[2:0] : 3'd4;
        bad  = fmt_reg != 16'd1 || (bits_reg != 16'd8 && bits_reg != 16'd16) ||
               (chan_reg != 16'd1 && chan_reg != 16'd2) || rate_reg == 32'd0;
    end

    always_comb
    begin
        phase_next = phase_reg;  bif_next = bif_reg;    shift_next = shift_reg;
        tag_next = tag_reg;      len_next = len_reg;    skip_next = skip_reg;
        fmt_next = fmt_reg;      chan_next = chan_reg;  rate_next = rate_reg;
        bits_next = bits_reg;    seen_next = seen_reg;  fcnt_next = fcnt_reg;
        left_next = left_reg;    fsize_next = fsize_reg; fsh_next = fsh_reg;
        data_wr = 1'b0;
        emit = 1'b0;
        j = '0;
        j.op = OP_STATUS;
        j.res.sample = MID_LEVEL;
        if (in_word.command == CMD_BEGIN || in_word.command == CMD_STOP)
        begin
            phase_next = (in_word.command == CMD_BEGIN) ? PH_RIFF : PH_IDLE;
            bif_next = '0; shift_next = '0; tag_next = '0; len_next = '0;
            skip_next = '0; fmt_next = '0; chan_next = '0; rate_next = '0;
            bits_next = '0; seen_next = 1'b0; fcnt_next = '0; left_next = '0;
            emit = 1'b1;
            j.res.kind = K_IDLE;
        end
        else if (in_word.command == CMD_BYTE && phase_reg != PH_IDLE &&
                 phase_reg != PH_DONE)
        begin
            unique case (phase_reg)
                PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CLEN:
                begin
                    if (bif_reg[1:0] != 2'd3)
                    begin
                        shift_next = v;
                        bif_next = bif_reg + 4'd1;
                    end
                    else
                    begin
                        shift_next = '0;
                        bif_next = '0;
                        unique case (phase_reg)
                            PH_RIFF:
                            begin
                                phase_next = PH_RSIZE;
                                if (v != TAG_RIFF)
                                begin
                                    phase_next = PH_DONE; emit = 1'b1;
                                    j.res.kind = K_MALFORMED;
                                end
                            end
                            PH_RSIZE: phase_next = PH_WAVE;
                            PH_WAVE:
                            begin
                                phase_next = PH_CTAG;
                                if (v != TAG_WAVE)
                                begin
                                    phase_next = PH_DONE; emit = 1'b1;
                                    j.res.kind = K_MALFORMED;
                                end
                            end
                            PH_CTAG:
                            begin
                                tag_next = v; phase_next = PH_CLEN;
                            end
                            default:
                            begin
                                len_next = v;
                                if (tag_reg == TAG_FMT)
                                begin
                                    if (v < 32'd16)
                                    begin
                                        phase_next = PH_DONE; emit = 1'b1;
                                        j.res.kind = K_MALFORMED;
                                    end
                                    else
                                    begin
                                        fmt_next = '0; chan_next = '0;
                                        rate_next = '0; bits_next = '0;
                                        phase_next = PH_FMT;
                                    end
                                end
                                else if (tag_reg == TAG_DATA)
                                begin
                                    emit = 1'b1;
                                    phase_next = PH_DONE;
                                    if (!seen_reg)
                                        j.res.kind = K_MALFORMED;
                                    else
                                    begin
                                        j.res.sample_rate = rate_reg;
                                        j.res.channels = chan_reg;
                                        j.res.bits_per_sample = bits_reg;
                                        if (bad)
                                            j.res.kind = K_UNSUP;
                                        else
                                        begin
                                            // Frame size is 1, 2 or 4 here.
                                            j.res.kind = K_HEADER;
                                            j.res.total_frames = v >> fsh_reg;
                                            left_next = v >> fsh_reg;
                                            fcnt_next = '0;
                                            fsize_next = fsz3;
                                            phase_next = ((v >> fsh_reg) != 32'd0) ?
                                                         PH_DATA : PH_FINISH;
                                        end
                                    end
                                end
                                else
                                begin
                                    skip_next = {1'b0, v} + {32'd0, v[0]};
                                    phase_next = (v == 32'd0) ? PH_CTAG : PH_SKIP;
                                end
                            end
                        endcase
                    end
                end
                PH_FMT:
                begin
                    priority if (bif_reg < 4'd2)
                        fmt_next = fmt_reg | (16'(in_word.data_byte) << {bif_reg[0], 3'b000});
                    else if (bif_reg < 4'd4)
                        chan_next = chan_reg | (16'(in_word.data_byte) << {bif_reg[0], 3'b000});
                    else if (bif_reg < 4'd8)
                        rate_next = rate_reg |
                                    (32'(in_word.data_byte) << {bif_reg[1:0], 3'b000});
                    else if (bif_reg >= 4'd14)
                        bits_next = bits_reg | (16'(in_word.data_byte) << {bif_reg[0], 3'b000});
                    else
                        bits_next = bits_reg;
                    bif_next = bif_reg + 4'd1;
                    if (bif_reg == 4'd15)
                    begin
                        seen_next = 1'b1;
                        skip_next = {1'b0, len_reg - 32'd16} + {32'd0, len_reg[0]};
                        phase_next = (skip_next == 33'd0) ? PH_CTAG : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 33'd1;
                    if (skip_reg <= 33'd1)
                    begin
                        skip_next = '0;
                        phase_next = PH_CTAG;
                    end
                end
                PH_DATA:
                begin
                    data_wr = 1'b1;
                    fcnt_next = fcnt_reg + 3'd1;
                    if (fcnt_next == fsize_reg)
                    begin
                        fcnt_next = '0;
                        left_next = left_reg - 32'd1;
                        if (left_reg <= 32'd1)
                        begin
                            left_next = '0;
                            phase_next = PH_FINISH;
                        end
                        emit = 1'b1;
                        j.res.kind = K_SAMPLE;
                        j.op = (bits_reg == 16'd8) ? OP_MIX8 : OP_MIX16;
                        j.stereo = chan_reg == 16'd2;
                        j.frame = {fb_reg[3], fb_reg[2], fb_reg[1], fb_reg[0]};
                        unique case (fcnt_reg[1:0])
                            2'd0: j.frame[7:0] = in_word.data_byte;
                            2'd1: j.frame[15:8] = in_word.data_byte;
                            2'd2: j.frame[23:16] = in_word.data_byte;
                            default: j.frame[31:24] = in_word.data_byte;
                        endcase
                    end
                end
                PH_FINISH:
                begin
                    phase_next = PH_DONE; emit = 1'b1;
                    j.res.kind = K_FINISHED;
                end
                default: ;
            endcase
            if (in_word.end_of_stream && phase_next != PH_DONE)
            begin
                if (!emit)
                begin
                    emit = 1'b1;
                    j.res.kind = (phase_next == PH_DATA) ? K_TRUNC : K_MALFORMED;
                end
                phase_next = PH_DONE;
            end
        end
        fsh_next = (fsz3 == 3'd4) ? 2'd2 : (fsz3 == 3'd2) ? 2'd1 : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; bif_reg <= '0; shift_reg <= '0; tag_reg <= '0;
            len_reg <= '0; skip_reg <= '0; fmt_reg <= '0; chan_reg <= '0;
            rate_reg <= '0; bits_reg <= '0; seen_reg <= 1'b0; fcnt_reg <= '0;
            left_reg <= '0; fsize_reg <= 3'd4; fsh_reg <= 2'd2;
        end
        else if (take)
        begin
            phase_reg <= phase_next; bif_reg <= bif_next; shift_reg <= shift_next;
            tag_reg <= tag_next; len_reg <= len_next; skip_reg <= skip_next;
            fmt_reg <= fmt_next; chan_reg <= chan_next; rate_reg <= rate_next;
            bits_reg <= bits_next; seen_reg <= seen_next; fcnt_reg <= fcnt_next;
            left_reg <= left_next; fsize_reg <= fsize_next; fsh_reg <= fsh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && data_wr)
            fb_reg[fcnt_reg[1:0]] <= in_word.data_byte;
    end

    assign job_valid = take && emit;
    assign job       = j;
endmodule

// ===== design/wav_queue.sv =====
module wav_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    input  wav_pkg::wav_job_t wr_job,
    output logic              wr_ready,
    output logic              rd_valid,
    output wav_pkg::wav_job_t rd_job,
    input  logic              rd_ready
);
    import wav_pkg::*;

    wav_job_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job   = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_job;
    end
endmodule

// ===== design/wav_mix.sv =====
module wav_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  wav_pkg::wav_job_t job,
    output logic              job_ready,
    output logic              out_valid,
    output wav_pkg::wav_out_t out_word,
    input  logic              out_ready
);
    import wav_pkg::*;

    logic        valid_reg;
    wav_out_t    word_reg;
    wav_out_t    word_next;
    logic [8:0]  s8;
    logic signed [16:0] sum16;
    logic signed [16:0] avg16;
    logic [16:0] off16;

    assign job_ready = !valid_reg || out_ready;

    always_comb
    begin
        word_next = job.res;
        s8 = {1'b0, job.frame[7:0]} + (job.stereo ? {1'b0, job.frame[15:8]} : 9'd0);
        sum16 = 17'(signed'(job.frame[15:0])) +
                (job.stereo ? 17'(signed'(job.frame[31:16])) : 17'sd0);
        // Halve with truncation toward zero.
        avg16 = job.stereo ? ((sum16 + 17'(sum16[16])) >>> 1) : sum16;
        off16 = 17'(avg16) + 17'd32768;
        unique case (job.op)
            OP_MIX8:  word_next.sample = job.stereo ? s8[8:1] : s8[7:0];
            OP_MIX16: word_next.sample = off16[15:8];
            default:  word_next.sample = job.res.sample;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (job_ready)
            valid_reg <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
endmodule

// ===== design/wav_stream_to_dac_samples.sv =====
// WAV byte stream to 8-bit DAC samples.
// Input channel in_valid/in_ready carries one word: a command and a file byte.
// Begin or stop answers an idle word; file bytes walk the RIFF header and chunks,
// the data chunk header answers header accepted (or a status), and each complete
// frame answers one unsigned sample. Most bytes answer nothing.
// The parser takes one word per cycle and is stalled only when the two-entry
// queue in front of the mixing stage is full. A result passes through the queue
// and the output register before it appears on out_valid/out_ready.
// Throughput is one word per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the output register holds its word, the queue
// fills and then in_ready drops until space frees up.
// Reset clears the parser to idle (no file open) and empties queue and output.
module wav_stream_to_dac_samples (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wav_pkg::wav_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output wav_pkg::wav_out_t out_data
);
    import wav_pkg::*;

    logic     pj_valid, pj_ready, qj_valid, qj_ready;
    wav_job_t pj, qj;

    wav_parse u_parse (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_word(in_data),
        .in_ready(in_ready), .job_valid(pj_valid), .job(pj), .job_ready(pj_ready)
    );

    wav_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(pj_valid), .wr_job(pj),
        .wr_ready(pj_ready), .rd_valid(qj_valid), .rd_job(qj), .rd_ready(qj_ready)
    );

    wav_mix u_mix (
        .clk(clk), .rst_n(rst_n), .job_valid(qj_valid), .job(qj),
        .job_ready(qj_ready), .out_valid(out_valid), .out_word(out_data),
        .out_ready(out_ready)
    );
endmodule

// ===== design/wav_checker.sv =====
module wav_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  wav_pkg::wav_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  wav_pkg::wav_out_t out_data
);
    import wav_pkg::*;

    // An accepted begin or stop command must be followed by out_valid high.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.command == CMD_BEGIN ||
        in_data.command == CMD_STOP) |-> ##2 out_valid)
        else $error("command gave no result");

    a_status_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != K_SAMPLE |-> out_data.sample == MID_LEVEL)
        else $error("status word without idle level");

    a_frames: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != K_HEADER |-> out_data.total_frames == 32'd0)
        else $error("frame count outside header word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
endmodule

bind wav_stream_to_dac_samples wav_checker u_wav_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import wav_pkg::*;

    localparam int ITEM_TARGET    = 1450;
    localparam int QUIET_FROM     = 1200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 80;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CLEN,
        PH_FMT, PH_SKIP, PH_DATA, PH_FINISH, PH_DONE
    } parse_phase_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    wav_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    wav_out_t out_data;

    wav_stream_to_dac_samples u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Parser state mirrored by the predictor.
    parse_phase_t p_phase;
    logic [4:0]   p_byte_idx;
    logic [31:0]  p_shift;
    logic [31:0]  p_tag;
    logic [31:0]  p_len;
    logic [32:0]  p_skip;
    logic [15:0]  p_fmt_tag;
    logic [15:0]  p_chans;
    logic [31:0]  p_rate;
    logic [15:0]  p_bits;
    logic         p_fmt_seen;
    logic [7:0]   p_frame [4];
    logic [2:0]   p_frame_cnt;
    logic [31:0]  p_frames_left;

    wav_out_t     pending_results[$];
    wav_in_t      file_words[$];
    int           errors;
    int           items_sent;
    int           results_seen;
    int           samples_seen;
    int           headers_seen;
    bit           quiet;
    bit           long_hold_req;
    int           idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wav_out_t status_word(logic [2:0] k);
        wav_out_t r;
        r = '0;
        r.kind = k;
        r.sample = MID_LEVEL;
        return r;
    endfunction

    function automatic void clear_parser();
        p_phase = PH_IDLE;
        p_byte_idx = '0;
        p_shift = '0;
        p_tag = '0;
        p_len = '0;
        p_skip = '0;
        p_fmt_tag = '0;
        p_chans = '0;
        p_rate = '0;
        p_bits = '0;
        p_fmt_seen = 1'b0;
        p_frame_cnt = '0;
        p_frames_left = '0;
        for (int i = 0; i < 4; i++)
            p_frame[i] = '0;
    endfunction

    function automatic int unsigned frame_bytes();
        int unsigned f;
        f = (p_bits / 8) * p_chans;
        return (f >= 1 && f <= 4) ? f : 4;
    endfunction

    function automatic logic [7:0] mix_frame();
        int mixed;
        int right;
        int unsigned u;
        if (p_bits == 16'd8)
        begin
            mixed = p_frame[0];
            if (p_chans == 16'd2)
                mixed = (mixed + int'(p_frame[1])) / 2;
            return mixed[7:0];
        end
        mixed = int'($signed({p_frame[1], p_frame[0]}));
        if (p_chans == 16'd2)
        begin
            right = int'($signed({p_frame[3], p_frame[2]}));
            mixed = (mixed + right) / 2;
        end
        u = mixed + 32768;
        return u[15:8];
    endfunction

    function automatic void enter_skip(logic [32:0] n);
        p_skip = n;
        p_phase = (n != 0) ? PH_SKIP : PH_CTAG;
    endfunction

    function automatic bit data_header(logic [31:0] len, output wav_out_t r);
        logic [31:0] frames;
        if (!p_fmt_seen)
        begin
            p_phase = PH_DONE;
            r = status_word(K_MALFORMED);
            return 1;
        end
        r = status_word(K_UNSUP);
        r.sample_rate = p_rate;
        r.channels = p_chans;
        r.bits_per_sample = p_bits;
        if (p_fmt_tag != 16'd1 || (p_bits != 16'd8 && p_bits != 16'd16) ||
            (p_chans != 16'd1 && p_chans != 16'd2) || p_rate == 0)
        begin
            p_phase = PH_DONE;
            return 1;
        end
        frames = len / frame_bytes();
        p_frames_left = frames;
        p_frame_cnt = '0;
        p_phase = (frames != 0) ? PH_DATA : PH_FINISH;
        r.kind = K_HEADER;
        r.total_frames = frames;
        return 1;
    endfunction

    function automatic bit parse_byte(logic [7:0] b, output wav_out_t r);
        logic [31:0] v;
        int unsigned i;
        r = '0;
        case (p_phase)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CLEN:
            begin
                p_shift = p_shift | (32'(b) << (8 * p_byte_idx[1:0]));
                p_byte_idx = p_byte_idx + 1;
                if (p_byte_idx < 4)
                    return 0;
                v = p_shift;
                p_shift = '0;
                p_byte_idx = '0;
                case (p_phase)
                    PH_RIFF:
                    begin
                        if (v != TAG_RIFF)
                        begin
                            p_phase = PH_DONE;
                            r = status_word(K_MALFORMED);
                            return 1;
                        end
                        p_phase = PH_RSIZE;
                    end
                    PH_RSIZE: p_phase = PH_WAVE;
                    PH_WAVE:
                    begin
                        if (v != TAG_WAVE)
                        begin
                            p_phase = PH_DONE;
                            r = status_word(K_MALFORMED);
                            return 1;
                        end
                        p_phase = PH_CTAG;
                    end
                    PH_CTAG:
                    begin
                        p_tag = v;
                        p_phase = PH_CLEN;
                    end
                    default:
                    begin
                        p_len = v;
                        if (p_tag == TAG_FMT)
                        begin
                            if (v < 16)
                            begin
                                p_phase = PH_DONE;
                                r = status_word(K_MALFORMED);
                                return 1;
                            end
                            p_fmt_tag = '0;
                            p_chans = '0;
                            p_rate = '0;
                            p_bits = '0;
                            p_phase = PH_FMT;
                        end
                        else if (p_tag == TAG_DATA)
                            return data_header(v, r);
                        else
                            enter_skip(33'(v) + 33'(v[0]));
                    end
                endcase
                return 0;
            end
            PH_FMT:
            begin
                i = p_byte_idx[3:0];
                if (i < 2)
                    p_fmt_tag = p_fmt_tag | (16'(b) << (8 * i));
                else if (i < 4)
                    p_chans = p_chans | (16'(b) << (8 * (i - 2)));
                else if (i < 8)
                    p_rate = p_rate | (32'(b) << (8 * (i - 4)));
                else if (i >= 14)
                    p_bits = p_bits | (16'(b) << (8 * (i - 14)));
                p_byte_idx = 5'(i + 1);
                if (p_byte_idx == 16)
                begin
                    p_byte_idx = '0;
                    p_fmt_seen = 1'b1;
                    enter_skip(33'(p_len - 32'd16) + 33'(p_len[0]));
                end
                return 0;
            end
            PH_SKIP:
            begin
                if (p_skip != 0)
                    p_skip = p_skip - 1;
                if (p_skip == 0)
                    p_phase = PH_CTAG;
                return 0;
            end
            PH_DATA:
            begin
                p_frame[p_frame_cnt[1:0]] = b;
                p_frame_cnt = p_frame_cnt + 1;
                if (p_frame_cnt < frame_bytes())
                    return 0;
                p_frame_cnt = '0;
                if (p_frames_left != 0)
                    p_frames_left = p_frames_left - 1;
                if (p_frames_left == 0)
                    p_phase = PH_FINISH;
                r = '0;
                r.kind = K_SAMPLE;
                r.sample = mix_frame();
                return 1;
            end
            PH_FINISH:
            begin
                p_phase = PH_DONE;
                r = status_word(K_FINISHED);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic bit predict_word(wav_in_t w, output wav_out_t r);
        bit got;
        parse_phase_t ph;
        r = '0;
        if (w.command == CMD_BEGIN || w.command == CMD_STOP)
        begin
            clear_parser();
            if (w.command == CMD_BEGIN)
                p_phase = PH_RIFF;
            r = status_word(K_IDLE);
            return 1;
        end
        if (w.command != CMD_BYTE || p_phase == PH_IDLE || p_phase == PH_DONE)
            return 0;
        got = parse_byte(w.data_byte, r);
        if (!w.end_of_stream || p_phase == PH_DONE)
            return got;
        ph = p_phase;
        p_phase = PH_DONE;
        if (got)
            return 1;
        r = status_word(ph == PH_DATA ? K_TRUNC : K_MALFORMED);
        return 1;
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %0s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    task automatic compare_words(string tag, wav_out_t got, wav_out_t want);
        if (got.kind != want.kind)
            report({tag, " kind"}, got.kind, want.kind);
        if (got.sample != want.sample)
            report({tag, " sample"}, got.sample, want.sample);
        if (got.sample_rate != want.sample_rate)
            report({tag, " sample_rate"}, got.sample_rate, want.sample_rate);
        if (got.channels != want.channels)
            report({tag, " channels"}, got.channels, want.channels);
        if (got.bits_per_sample != want.bits_per_sample)
            report({tag, " bits_per_sample"}, got.bits_per_sample, want.bits_per_sample);
        if (got.total_frames != want.total_frames)
            report({tag, " total_frames"}, got.total_frames, want.total_frames);
    endtask

    // Offers one word and returns once it has been taken, with its prediction.
    task automatic send_word(wav_in_t w, output bit got, output wav_out_t r);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_data = w;
        in_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        got = predict_word(w, r);
        if (got)
            pending_results.push_back(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_plain(wav_in_t w);
        bit got;
        wav_out_t r;
        send_word(w, got, r);
    endtask

    function automatic wav_in_t file_byte(logic [7:0] b);
        wav_in_t w;
        w.command = CMD_BYTE;
        w.data_byte = b;
        w.end_of_stream = 1'b0;
        return w;
    endfunction

    function automatic void push_bytes(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_words.push_back(file_byte(v[8 * i +: 8]));
    endfunction

    function automatic void push_fmt(logic [31:0] len, logic [15:0] ftag, logic [15:0] ch,
                                     logic [31:0] rate, logic [15:0] bits);
        push_bytes(TAG_FMT, 4);
        push_bytes(len, 4);
        if (len < 16)
            return;
        push_bytes(ftag, 2);
        push_bytes(ch, 2);
        push_bytes(rate, 4);
        push_bytes($urandom, 4);
        push_bytes($urandom, 2);
        push_bytes(bits, 2);
        for (int i = 16; i < len + len[0]; i++)
            file_words.push_back(file_byte($urandom));
    endfunction

    // Builds one file, mostly well formed, with a few kinds of damage mixed in.
    function automatic void build_file();
        int unsigned shape;
        logic [15:0] ch;
        logic [15:0] bits;
        logic [15:0] ftag;
        logic [31:0] rate;
        logic [31:0] dlen;
        logic [31:0] flen;
        int unsigned nbytes;
        int unsigned cut;
        wav_in_t w;
        file_words.delete();
        w = '0;
        w.command = CMD_BEGIN;
        w.data_byte = $urandom;
        w.end_of_stream = $urandom;
        file_words.push_back(w);
        shape = $urandom_range(0, 19);
        push_bytes(shape == 0 ? $urandom : TAG_RIFF, 4);
        push_bytes($urandom, 4);
        push_bytes(shape == 1 ? $urandom : TAG_WAVE, 4);
        if ($urandom_range(0, 3) == 0)
        begin
            flen = $urandom_range(0, 7);
            push_bytes($urandom, 4);
            push_bytes(flen, 4);
            for (int i = 0; i < flen + flen[0]; i++)
                file_words.push_back(file_byte($urandom));
        end
        ch = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
        bits = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ($urandom_range(0, 1) ? 16'd8 : 16'd16);
        ftag = ($urandom_range(0, 14) == 0) ? 16'($urandom) : 16'd1;
        rate = ($urandom_range(0, 14) == 0) ? 32'd0 : 32'($urandom);
        flen = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(16, 21)) : 32'd16;
        if (shape == 2)
            flen = $urandom_range(0, 15);
        if (shape == 3)
            push_fmt(16, $urandom, $urandom, $urandom, $urandom);
        if (shape != 4)
            push_fmt(flen, ftag, ch, rate, bits);
        if (shape == 5)
            dlen = $urandom;
        else
            dlen = $urandom_range(0, 24);
        push_bytes(TAG_DATA, 4);
        push_bytes(dlen, 4);
        nbytes = (dlen > 40) ? 40 : dlen;
        nbytes = nbytes + $urandom_range(0, 3);
        for (int i = 0; i < nbytes; i++)
            file_words.push_back(file_byte($urandom));
        // The last byte usually ends the stream; sometimes the cut is earlier.
        if ($urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, file_words.size() - 1);
            file_words[cut].end_of_stream = 1'b1;
        end
        else if ($urandom_range(0, 3) != 0)
            file_words[file_words.size() - 1].end_of_stream = 1'b1;
    endfunction

    typedef struct {
        wav_in_t  word;
        bit       typed;
        wav_out_t want;
    } stim_row_t;

    function automatic stim_row_t row(logic [1:0] cmd, logic [7:0] b, logic eos,
                                      bit typed, logic [2:0] k);
        stim_row_t s;
        s.word.command = cmd;
        s.word.data_byte = b;
        s.word.end_of_stream = eos;
        s.typed = typed;
        s.want = status_word(k);
        return s;
    endfunction

    initial
    begin
        stim_row_t table_rows[$];
        bit got;
        wav_out_t r;
        wav_in_t w;
        bit pause_done;
        bit hold_done;

        errors = 0;
        items_sent = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        pause_done = 1'b0;
        hold_done = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        clear_parser();
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        table_rows.push_back(row(CMD_BYTE, 8'hFF, 1'b1, 0, K_IDLE));
        table_rows.push_back(row(2'd3, 8'h00, 1'b0, 0, K_IDLE));
        table_rows.push_back(row(CMD_BEGIN, 8'hFF, 1'b1, 1, K_IDLE));
        table_rows.push_back(row(CMD_BYTE, 8'h00, 1'b0, 0, K_IDLE));
        table_rows.push_back(row(CMD_BYTE, 8'hFF, 1'b0, 0, K_IDLE));
        table_rows.push_back(row(CMD_BYTE, 8'h00, 1'b0, 0, K_IDLE));
        table_rows.push_back(row(CMD_BYTE, 8'hFF, 1'b0, 1, K_MALFORMED));
        table_rows.push_back(row(CMD_BYTE, 8'h52, 1'b1, 0, K_IDLE));
        table_rows.push_back(row(CMD_STOP, 8'h00, 1'b0, 1, K_IDLE));
        table_rows.push_back(row(CMD_BYTE, 8'h52, 1'b0, 0, K_IDLE));
        table_rows.push_back(row(CMD_BEGIN, 8'h00, 1'b0, 1, K_IDLE));
        for (int i = 0; i < 4; i++)
            table_rows.push_back(row(CMD_BYTE, TAG_RIFF[8 * i +: 8], 1'b0, 0, K_IDLE));
        for (int i = 0; i < 4; i++)
            table_rows.push_back(row(CMD_BYTE, 8'h00, 1'b0, 0, K_IDLE));
        table_rows.push_back(row(CMD_BYTE, 8'h57, 1'b1, 1, K_MALFORMED));
        table_rows.push_back(row(CMD_BEGIN, 8'h00, 1'b0, 1, K_IDLE));
        table_rows.push_back(row(CMD_BYTE, 8'h52, 1'b1, 1, K_MALFORMED));
        table_rows.push_back(row(2'd3, 8'hFF, 1'b1, 0, K_IDLE));
        table_rows.push_back(row(CMD_STOP, 8'hFF, 1'b1, 1, K_IDLE));

        foreach (table_rows[i])
        begin
            send_word(table_rows[i].word, got, r);
            if (table_rows[i].typed)
            begin
                if (!got)
                    report("directed row gave no result", i, 1);
                else
                    compare_words("directed", r, table_rows[i].want);
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_FROM)
                quiet = 1'b1;
            if (!hold_done && items_sent > 300)
            begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent > 700)
            begin
                in_valid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                // Loose words between files.
                repeat ($urandom_range(1, 6))
                begin
                    w.command = $urandom;
                    w.data_byte = $urandom;
                    w.end_of_stream = $urandom;
                    send_plain(w);
                end
            end
            else
            begin
                build_file();
                foreach (file_words[i])
                    send_plain(file_words[i]);
            end
        end
        in_valid = 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("sent %0d words over random WAV files, stops and noise", items_sent);
        $display("checked %0d results: %0d samples, %0d accepted headers",
                 results_seen, samples_seen, headers_seen);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                out_ready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                idle_left = $urandom_range(1, 11) - 1;
                out_ready = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        wav_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report("result with nothing pending, kind", out_data.kind, 0);
            else
            begin
                want = pending_results.pop_front();
                compare_words("result", out_data, want);
                if (want.kind == K_SAMPLE)
                    samples_seen++;
                if (want.kind == K_HEADER)
                    headers_seen++;
            end
        end
    end

    // Ends the run if neither side moves a word for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        results_seen = 0;
        samples_seen = 0;
        headers_seen = 0;
        idle_cycles = 0;
    end

endmodule

// ===== wav_stream_to_dac_samples.f =====
design/wav_pkg.sv
design/wav_parse.sv
design/wav_queue.sv
design/wav_mix.sv
design/wav_stream_to_dac_samples.sv
design/wav_checker.sv
tb/sv/testbench.sv
